/* rtl/assert_macros.svh */
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on a given clock, disabled while reset is low
`define PIDR_ASSERT_CR(label, prop, clk, rst, msg) \
  label: assert property (@(posedge clk) disable iff (!rst) prop) else $error(msg);

// property checked on the block clock and reset
`define PIDR_ASSERT(label, prop, msg) \
  `PIDR_ASSERT_CR(label, prop, clk_i, rst_ni, msg)

`endif

/* rtl/pidr_pkg.sv */
package pidr_pkg;

  localparam int unsigned CFG_INDEX_W = 4;

  localparam int unsigned REG_GAIN_P    = 0;
  localparam int unsigned REG_GAIN_I    = 1;
  localparam int unsigned REG_GAIN_D    = 2;
  localparam int unsigned REG_STEP_TIME = 3;
  localparam int unsigned REG_STEP_RATE = 4;
  localparam int unsigned REG_OUT_UPPER = 5;
  localparam int unsigned REG_OUT_LOWER = 6;
  localparam int unsigned REG_DEAD_BAND = 7;

  localparam logic signed [31:0] RST_GAIN_P    = 32'sd65536;
  localparam logic signed [31:0] RST_GAIN_I    = 32'sd0;
  localparam logic signed [31:0] RST_GAIN_D    = 32'sd0;
  localparam logic        [30:0] RST_STEP_TIME = 31'd655;
  localparam logic        [30:0] RST_STEP_RATE = 31'd6553600;
  localparam logic signed [31:0] RST_OUT_UPPER = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RST_OUT_LOWER = 32'sh8000_0000;
  localparam logic        [15:0] RST_DEAD_BAND = 16'd66;

  typedef struct packed {
    logic signed [31:0] target;
    logic signed [31:0] measured;
  } in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] p_part;
    logic signed [31:0] i_part;
    logic signed [31:0] d_part;
  } out_t;

  typedef struct packed {
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic        [30:0] step_time;
    logic        [30:0] step_rate;
    logic signed [31:0] out_upper;
    logic signed [31:0] out_lower;
    logic        [15:0] dead_band;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_P   = 3'd0,
    OP_INC = 3'd1,
    OP_DER = 3'd2,
    OP_I   = 3'd3,
    OP_D   = 3'd4
  } op_e;

  typedef struct packed {
    logic capture;
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic wb;
    logic finish;
    op_e  op;
  } cmd_t;

endpackage

/* rtl/pidr_regs.sv */
module pidr_regs import pidr_pkg::*; #(
  parameter int unsigned CfgIndexWidth = CFG_INDEX_W
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [31:0]              cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgIndexWidth'(REG_GAIN_P):    cfg_d.gain_p    = cfg_data_i;
        CfgIndexWidth'(REG_GAIN_I):    cfg_d.gain_i    = cfg_data_i;
        CfgIndexWidth'(REG_GAIN_D):    cfg_d.gain_d    = cfg_data_i;
        CfgIndexWidth'(REG_STEP_TIME): cfg_d.step_time = cfg_data_i[30:0];
        CfgIndexWidth'(REG_STEP_RATE): cfg_d.step_rate = cfg_data_i[30:0];
        CfgIndexWidth'(REG_OUT_UPPER): cfg_d.out_upper = cfg_data_i;
        CfgIndexWidth'(REG_OUT_LOWER): cfg_d.out_lower = cfg_data_i;
        CfgIndexWidth'(REG_DEAD_BAND): cfg_d.dead_band = cfg_data_i[15:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p    <= RST_GAIN_P;
      cfg_q.gain_i    <= RST_GAIN_I;
      cfg_q.gain_d    <= RST_GAIN_D;
      cfg_q.step_time <= RST_STEP_TIME;
      cfg_q.step_rate <= RST_STEP_RATE;
      cfg_q.out_upper <= RST_OUT_UPPER;
      cfg_q.out_lower <= RST_OUT_LOWER;
      cfg_q.dead_band <= RST_DEAD_BAND;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/pidr_ctrl.sv */
module pidr_ctrl import pidr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_MLO  = 6'b000100,
    S_MHI  = 6'b001000,
    S_WB   = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.op    = op_q;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          op_d          = OP_P;
          state_d       = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_MLO;
      end
      S_MLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MHI;
      end
      S_MHI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_WB;
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = S_LOAD;
        case (op_q)
          OP_P:    op_d = OP_INC;
          OP_INC:  op_d = OP_DER;
          OP_DER:  op_d = OP_I;
          OP_I:    op_d = OP_D;
          OP_D:    state_d = S_FIN;
          default: state_d = S_FIN;
        endcase
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_P;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/pidr_dpath.sv */
module pidr_dpath import pidr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  cmd_t cmd_i,
  input  in_t  in_data_i,
  output out_t out_data_o
);

  localparam logic [63:0] CAP32_POS = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] CAP32_NEG = 64'h0000_0000_8000_0000;
  localparam logic [63:0] CAP48_POS = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] CAP48_NEG = 64'h0000_8000_0000_0000;

  logic signed [32:0] err_q, err_d, last_q, last_d;
  logic signed [47:0] sum_q, sum_d, deriv_q, deriv_d;
  logic signed [31:0] p_q, p_d, i_q, i_d, d_q, d_d;
  logic        [31:0] ma_q, ma_d;
  logic        [47:0] mb_q, mb_d;
  logic               neg_q, neg_d;
  logic        [79:0] acc_q, acc_d;
  out_t               out_q, out_d;

  logic        [32:0] aerr;
  logic               clear;
  logic signed [33:0] diff;
  logic signed [31:0] a_sel;
  logic signed [47:0] b_sel;
  logic        [55:0] part;
  logic        [63:0] mag, c32, c48, n32, n48, cap32, cap48;
  logic        [31:0] r32;
  logic        [47:0] r48;
  logic signed [48:0] s49;
  logic        [47:0] sum_sat;
  logic signed [33:0] total, upper, lower;

  // integral reset on sign change, zero current or previous error, or error inside dead band
  always_comb begin
    aerr  = err_q[32] ? -err_q : err_q;
    clear = (err_q == '0) || (last_q == '0) || (err_q[32] ^ last_q[32]) ||
            (aerr < {17'b0, cfg_i.dead_band});
  end

  // operand select and magnitudes for the shared multiplier
  always_comb begin
    diff = 34'(err_q) - 34'(last_q);
    case (cmd_i.op)
      OP_P: begin
        a_sel = cfg_i.gain_p;
        b_sel = 48'(err_q);
      end
      OP_INC: begin
        a_sel = $signed({1'b0, cfg_i.step_time});
        b_sel = 48'(err_q);
      end
      OP_DER: begin
        a_sel = $signed({1'b0, cfg_i.step_rate});
        b_sel = 48'(diff);
      end
      OP_I: begin
        a_sel = cfg_i.gain_i;
        b_sel = sum_q;
      end
      OP_D: begin
        a_sel = cfg_i.gain_d;
        b_sel = deriv_q;
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
    ma_d  = a_sel[31] ? -a_sel : a_sel;
    mb_d  = b_sel[47] ? -b_sel : b_sel;
    neg_d = a_sel[31] ^ b_sel[47];
  end

  // 32x24 partial products, low half then high half
  always_comb begin
    part = ma_q * (cmd_i.mul_hi ? mb_q[47:24] : mb_q[23:0]);
    if (cmd_i.mul_hi) begin
      acc_d = acc_q + {part, 24'b0};
    end else begin
      acc_d = 80'(part);
    end
  end

  // truncate toward zero, saturate magnitude, apply sign; saturating integral sum
  always_comb begin
    mag   = acc_q[79:16];
    cap32 = neg_q ? CAP32_NEG : CAP32_POS;
    cap48 = neg_q ? CAP48_NEG : CAP48_POS;
    c32   = (mag > cap32) ? cap32 : mag;
    c48   = (mag > cap48) ? cap48 : mag;
    n32   = -c32;
    n48   = -c48;
    r32   = neg_q ? n32[31:0] : c32[31:0];
    r48   = neg_q ? n48[47:0] : c48[47:0];
    s49   = $signed({sum_q[47], sum_q}) + $signed({r48[47], r48});
    if (s49[48] != s49[47]) begin
      sum_sat = s49[48] ? CAP48_NEG[47:0] : CAP48_POS[47:0];
    end else begin
      sum_sat = s49[47:0];
    end
  end

  // drive sum and clamp
  always_comb begin
    total = 34'(p_q) + 34'(i_q) + 34'(d_q);
    upper = 34'(cfg_i.out_upper);
    lower = 34'(cfg_i.out_lower);
    out_d = out_q;
    if (cmd_i.finish) begin
      out_d.p_part = p_q;
      out_d.i_part = i_q;
      out_d.d_part = d_q;
      if (total > upper) begin
        out_d.drive = cfg_i.out_upper;
      end else if (total < lower) begin
        out_d.drive = cfg_i.out_lower;
      end else begin
        out_d.drive = total[31:0];
      end
    end
  end

  always_comb begin
    err_d   = err_q;
    last_d  = last_q;
    sum_d   = sum_q;
    deriv_d = deriv_q;
    p_d     = p_q;
    i_d     = i_q;
    d_d     = d_q;
    if (cmd_i.capture) begin
      err_d = 33'(in_data_i.target) - 33'(in_data_i.measured);
    end
    if (cmd_i.load && (cmd_i.op == OP_P) && clear) begin
      sum_d = '0;
    end
    if (cmd_i.load && (cmd_i.op == OP_DER)) begin
      last_d = err_q;
    end
    if (cmd_i.wb) begin
      case (cmd_i.op)
        OP_P:    p_d     = r32;
        OP_INC:  sum_d   = sum_sat;
        OP_DER:  deriv_d = r48;
        OP_I:    i_d     = r32;
        OP_D:    d_d     = r32;
        default: p_d     = p_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      last_q <= '0;
    end else begin
      sum_q  <= sum_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    deriv_q <= deriv_d;
    p_q     <= p_d;
    i_q     <= i_d;
    d_q     <= d_d;
    out_q   <= out_d;
    if (cmd_i.load) begin
      ma_q  <= ma_d;
      mb_q  <= mb_d;
      neg_q <= neg_d;
    end
    if (cmd_i.mul_lo || cmd_i.mul_hi) begin
      acc_q <= acc_d;
    end
  end

  assign out_data_o = out_q;

endmodule

/* rtl/pid_controller_with_integral_reset_core.sv */
// the input is captured, the five products run, then finish registers the result
// one item at a time, no new input until finish; one 32x24 multiplier is shared by the
//   five products, each taking load, two partial products and writeback
// a held result does not block the next input; the finish step waits for it
// reset: registers to defaults, integral and previous error to zero, no result
module pid_controller_with_integral_reset_core import pidr_pkg::*; #(
  parameter int unsigned CfgIndexWidth = CFG_INDEX_W
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_t                      in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_t                     out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [31:0]              cfg_data_i
);

  cfg_t cfg;
  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  pidr_regs #(
    .CfgIndexWidth(CfgIndexWidth)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pidr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  pidr_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .cmd_i     (cmd),
    .in_data_i (in_data_i),
    .out_data_o(out_data_o)
  );

endmodule

/* rtl/pidr_checker.sv */
`include "assert_macros.svh"

module pidr_checker import pidr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // a stalled result holds
  `PIDR_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")

  // one request at a time
  `PIDR_ASSERT(a_busy_after_req, in_valid_i && in_ready_o |=> !in_ready_o, "input taken while busy")

  // a result cannot appear right after a request
  `PIDR_ASSERT(a_no_early_result, in_valid_i && in_ready_o |=> !$rose(out_valid_o), "result too early")

  // a new result leaves the block ready for the next request
  `PIDR_ASSERT(a_ready_on_result, $rose(out_valid_o) |-> in_ready_o, "not ready after result")

endmodule

bind pid_controller_with_integral_reset_core pidr_checker u_checker (.*);

/* tb/sv/pid_controller_with_integral_reset_core_test.sv */
`timescale 1ns / 1ps

module pid_controller_with_integral_reset_core_test;
  import pidr_pkg::*;

  localparam longint LIM32 = 64'sd2147483647;
  localparam longint LIM48 = 64'sd140737488355327;
  localparam int unsigned NUM_REGS = REG_DEAD_BAND + 1;
  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned CALM_ITEMS = 200;
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic req_valid = 1'b0;
  in_t req_data = '0;
  logic req_ready;
  logic res_valid;
  logic res_ready = 1'b0;
  out_t res_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pid_controller_with_integral_reset_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .in_data_i  (req_data),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .out_data_o (res_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // controller copy: register file, integral and previous error
  cfg_t regs = '{gain_p: RST_GAIN_P, gain_i: RST_GAIN_I, gain_d: RST_GAIN_D,
                 step_time: RST_STEP_TIME, step_rate: RST_STEP_RATE,
                 out_upper: RST_OUT_UPPER, out_lower: RST_OUT_LOWER,
                 dead_band: RST_DEAD_BAND};
  longint integ = 0;
  longint prev_err = 0;

  in_t req_q[$];
  out_t drive_due_q[$];
  out_t want;

  bit tx_gaps = 1'b0;
  bit rx_stalls = 1'b0;
  int tx_gap = 0;
  int rx_stall = 0;
  int unsigned queued = 0;
  int unsigned n_reqs = 0;
  int unsigned n_results = 0;
  int unsigned n_writes = 0;
  int unsigned n_phases = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // q16.16 product, truncated toward zero, saturated to lim or -lim-1
  function automatic longint qmul(longint a, longint b, longint lim);
    logic neg;
    logic [127:0] mag;
    logic [127:0] cap;
    neg = (a < 0) != (b < 0);
    mag = (128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b)) >> 16;
    cap = neg ? 128'(lim) + 128'd1 : 128'(lim);
    if (mag > cap) mag = cap;
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic longint sat48(longint v);
    if (v > LIM48) return LIM48;
    if (v < -LIM48 - 1) return -LIM48 - 1;
    return v;
  endfunction

  function automatic out_t pid_update(in_t req);
    longint err, aerr, p, i, d, deriv, total, drive, hi, lo;
    out_t res;
    err = longint'(req.target) - longint'(req.measured);
    aerr = err < 0 ? -err : err;
    if (err == 0 || prev_err == 0 || ((err < 0) != (prev_err < 0))) integ = 0;
    if (aerr < longint'(regs.dead_band)) integ = 0;
    p = qmul(regs.gain_p, err, LIM32);
    integ = sat48(integ + qmul(regs.step_time, err, LIM48));
    i = qmul(regs.gain_i, integ, LIM32);
    deriv = qmul(regs.step_rate, err - prev_err, LIM48);
    d = qmul(regs.gain_d, deriv, LIM32);
    total = p + i + d;
    hi = regs.out_upper;
    lo = regs.out_lower;
    if (total > hi) drive = hi;
    else if (total < lo) drive = lo;
    else drive = total;
    prev_err = err;
    res.drive = drive[31:0];
    res.p_part = p[31:0];
    res.i_part = i[31:0];
    res.d_part = d[31:0];
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, $signed(exp_v),
               $signed(act_v));
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // request driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
      req_data <= '0;
      tx_gap <= 0;
    end else if (!req_valid || req_ready) begin
      if (tx_gap != 0) begin
        req_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (req_q.size() != 0) begin
        req_valid <= 1'b1;
        req_data <= req_q.pop_front();
        if (tx_gaps && $urandom_range(0, 3) == 0) tx_gap <= $urandom_range(1, 3);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
      rx_stall <= 0;
    end else if (rx_stall != 0) begin
      res_ready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
      res_ready <= 1'b0;
      rx_stall <= $urandom_range(0, 2);
    end else begin
      res_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_valid && res_ready) begin
        n_results++;
        if (drive_due_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request pending, drive %0d", $time,
                   $signed(res_data.drive));
        end else begin
          want = drive_due_q.pop_front();
          check_field("drive", want.drive, res_data.drive);
          check_field("p_part", want.p_part, res_data.p_part);
          check_field("i_part", want.i_part, res_data.i_part);
          check_field("d_part", want.d_part, res_data.d_part);
        end
      end
      if (cfg_valid && cfg_ready) begin
        n_writes++;
        case (32'(cfg_index))
          REG_GAIN_P: regs.gain_p = cfg_data;
          REG_GAIN_I: regs.gain_i = cfg_data;
          REG_GAIN_D: regs.gain_d = cfg_data;
          REG_STEP_TIME: regs.step_time = cfg_data[30:0];
          REG_STEP_RATE: regs.step_rate = cfg_data[30:0];
          REG_OUT_UPPER: regs.out_upper = cfg_data;
          REG_OUT_LOWER: regs.out_lower = cfg_data;
          REG_DEAD_BAND: regs.dead_band = cfg_data[15:0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        n_reqs++;
        drive_due_q.push_back(pid_update(req_data));
      end
    end
  end

  function automatic logic [31:0] to_q(longint v);
    if (v > LIM32) return 32'h7FFF_FFFF;
    if (v < -LIM32 - 1) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] pick_word(int unsigned span);
    logic [31:0] w;
    case ($urandom_range(0, 7))
      0: w = 32'h7FFF_FFFF;
      1: w = 32'h8000_0000;
      2: w = '0;
      3: w = $urandom;
      default: begin
        w = $urandom_range(0, span);
        if ($urandom_range(0, 1) != 0) w = -w;
      end
    endcase
    return w;
  endfunction

  task automatic send(logic [31:0] t, logic [31:0] m);
    in_t r;
    r.target = t;
    r.measured = m;
    req_q.push_back(r);
    queued++;
  endtask

  // must be called right after a rising edge
  task automatic put_reg(int unsigned idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_INDEX_W'(idx);
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic settle();
    while (req_q.size() != 0 || req_valid || drive_due_q.size() != 0) @(posedge clk);
  endtask

  task automatic retune();
    int unsigned n, idx, span;
    n = ($urandom_range(0, 5) == 0) ? NUM_REGS : $urandom_range(1, 4);
    @(posedge clk);
    for (int k = 0; k < n; k++) begin
      if (n == NUM_REGS) idx = k;
      else if ($urandom_range(0, 9) == 0) idx = $urandom_range(NUM_REGS, (1 << CFG_INDEX_W) - 1);
      else idx = $urandom_range(0, NUM_REGS - 1);
      case (idx)
        REG_STEP_TIME: span = 1 << 17;
        REG_STEP_RATE: span = 1000 << 16;
        REG_OUT_UPPER, REG_OUT_LOWER: span = 200 << 16;
        REG_DEAD_BAND: span = 4000;
        default: span = 1 << 18;
      endcase
      put_reg(idx, pick_word(span));
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly runs of same-sign error so the integral builds up
  task automatic add_run();
    int unsigned len, kind;
    longint t, mag, dir, e;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      len = $urandom_range(3, 24);
      t = longint'($signed(pick_word(1 << 24)));
      case ($urandom_range(0, 3))
        0: mag = $urandom_range(1, 4096);
        1: mag = $urandom_range(1, 1 << 20);
        2: mag = $urandom_range(1, 1 << 30);
        default: mag = LIM32;
      endcase
      dir = ($urandom_range(0, 1) != 0) ? -1 : 1;
      for (int k = 0; k < len; k++) begin
        e = mag - (mag * k) / len + $urandom_range(0, 3);
        send(to_q(t), to_q(t - dir * e));
      end
    end else if (kind < 9) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 1) != 0) send($urandom, $urandom);
        else send(pick_word(1 << 20), pick_word(1 << 20));
      end
    end else begin
      // sign flips, zero error and dead band edge
      len = $urandom_range(2, 10);
      for (int k = 0; k < len; k++) begin
        t = longint'($signed(pick_word(1 << 24)));
        e = $urandom_range(0, 200);
        if ($urandom_range(0, 1) != 0) e = -e;
        send(to_q(t), to_q(t - e));
      end
    end
  endtask

  initial begin
    int unsigned goal, total;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    send(32'h0000_0000, 32'h0000_0000);
    send(32'h7FFF_FFFF, 32'h8000_0000);
    send(32'h8000_0000, 32'h7FFF_FFFF);
    send(32'd100, 32'd0);
    send(32'd200, 32'd0);
    send(32'd65, 32'd0);
    send(32'd0, 32'd1);
    send(32'hFFFF_FFFB, 32'hFFFF_FFFB);
    settle();
    n_phases++;

    // extreme gains, saturating integral, wide dead band
    @(posedge clk);
    put_reg(REG_GAIN_P, 32'h0002_8000);
    put_reg(REG_GAIN_I, 32'h8000_0000);
    put_reg(REG_GAIN_D, 32'h7FFF_FFFF);
    put_reg(REG_STEP_TIME, 32'hFFFF_FFFF);
    put_reg(REG_STEP_RATE, 32'h8000_0001);
    put_reg(REG_OUT_UPPER, 32'h0064_0000);
    put_reg(REG_OUT_LOWER, 32'hFF9C_0000);
    put_reg(REG_DEAD_BAND, 32'hABCD_FFFF);
    put_reg(NUM_REGS, $urandom);
    cfg_valid <= 1'b0;
    send(32'h7FFF_FFFF, 32'h0000_0000);
    send(32'h7FFF_FFFF, 32'h0000_0000);
    send(32'h7FFF_FFFF, 32'h0000_0000);
    send(32'h0000_0000, 32'd65534);
    send(32'h0000_0000, 32'h8000_0000);
    send(32'h8000_0000, 32'h0000_0000);
    send(32'h0005_0000, 32'h0000_0000);
    send(32'h0005_0000, 32'h0001_0000);
    settle();
    n_phases++;

    // zero step time and rate, crossed clamps, no dead band
    @(posedge clk);
    put_reg(REG_STEP_TIME, 32'h8000_0000);
    put_reg(REG_STEP_RATE, 32'h0000_0000);
    put_reg(REG_OUT_UPPER, 32'hFFFF_0000);
    put_reg(REG_OUT_LOWER, 32'h0001_0000);
    put_reg(REG_DEAD_BAND, 32'h0000_0000);
    put_reg(REG_GAIN_P, 32'h0001_0000);
    put_reg(REG_GAIN_I, 32'h0001_0000);
    put_reg(REG_GAIN_D, 32'h0001_0000);
    cfg_valid <= 1'b0;
    send(32'h0001_0000, 32'h0000_0000);
    send(32'hFFFF_0000, 32'h0000_0000);
    send(32'h0000_0000, 32'h0000_0000);
    send(32'h0000_0001, 32'h0000_0000);
    send(32'h0003_0000, 32'h0001_0000);
    send(32'h8000_0000, 32'h8000_0000);
    settle();
    n_phases++;

    total = queued + RANDOM_ITEMS;
    while (queued < total) begin
      if (queued + CALM_ITEMS >= total) begin
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
      end else begin
        tx_gaps = $urandom_range(0, 2) != 0;
        rx_stalls = $urandom_range(0, 2) != 0;
      end
      retune();
      goal = queued + $urandom_range(40, 160);
      while (queued < goal && queued < total) add_run();
      settle();
      n_phases++;
    end

    repeat (40) @(posedge clk);
    $display("tb: %0d requests over %0d setups, %0d register writes", n_reqs, n_phases,
             n_writes);
    $display("tb: %0d results checked, %0d mismatches", n_results, mismatches);
    if (mismatches == 0 && drive_due_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* pid_controller_with_integral_reset_core.f */
+incdir+rtl
rtl/pidr_pkg.sv
rtl/pidr_regs.sv
rtl/pidr_ctrl.sv
rtl/pidr_dpath.sv
rtl/pid_controller_with_integral_reset_core.sv
rtl/pidr_checker.sv
tb/sv/pid_controller_with_integral_reset_core_test.sv
